// File: rtl/iach_pkg.sv
// Shared types and codes of the incremental angular convex hull block.
package iach_pkg;

  // Request codes of the input channel.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_DUMP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W    = 1;
  localparam logic [0:0]  CFG_CENTER_X = 1'b0;
  localparam logic [0:0]  CFG_CENTER_Y = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_W,
    S_SCAN_END,
    S_EQ_N1,
    S_EQ_N1W,
    S_EQ_N2W,
    S_PAIR_A,
    S_PAIR_B,
    S_PAIR_X,
    S_PAIR_W,
    S_INS_RD,
    S_INS_WR,
    S_PR_CHK,
    S_ER_RD,
    S_ER_WR
  } state_t;

  // What a pair test is for: the insertion edge or one of the two prune walks.
  typedef enum logic [1:0] {
    CX_EDGE,
    CX_PRA,
    CX_PRB
  } ctx_t;

  // Angular order of the new point against a stored vertex.
  typedef enum logic [1:0] {
    ANG_BEFORE,
    ANG_AFTER,
    ANG_EQUAL
  } ang_t;

  typedef enum logic [1:0] {
    XP_IDLE,
    XP_MUL1,
    XP_MUL2,
    XP_SUM
  } xu_phase_t;

  // Command to the shared product unit: add selects a*d + b*c, else a*d - b*c.
  typedef struct packed {
    logic start;
    logic add;
  } xu_cmd_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } xu_sts_t;

endpackage

// File: rtl/iach_req_if.sv
// Request channel: one beat carries one hull request.
interface iach_req_if #(parameter int CW = 24);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;

  modport source (output valid, req_type, point_x, point_y, input ready);
  modport sink (input valid, req_type, point_x, point_y, output ready);
endinterface

// File: rtl/iach_res_if.sv
// Result channel: one beat carries one result item.
interface iach_res_if #(parameter int CW = 24, parameter int NW = 7);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic                 vertex_valid;
  logic                 point_added;
  logic [NW-1:0]        hull_count;
  logic                 overflow;
  logic                 last;

  modport source (output valid, vertex_x, vertex_y, vertex_valid, point_added,
                  hull_count, overflow, last, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_valid, point_added,
                hull_count, overflow, last, output ready);
endinterface

// File: rtl/iach_xunit.sv
// Shared product unit: one multiplier computes a*d +/- b*c, forming the two products in turn.
module iach_xunit #(
  parameter int OW = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  iach_pkg::xu_cmd_t     cmd,
  input  logic signed [OW-1:0]  ax,
  input  logic signed [OW-1:0]  ay,
  input  logic signed [OW-1:0]  bx,
  input  logic signed [OW-1:0]  by,
  output iach_pkg::xu_sts_t     sts,
  output logic signed [2*OW:0]  res
);
  import iach_pkg::*;

  xu_phase_t              ph;
  logic                   done;
  logic                   add_mode;
  logic signed [OW-1:0]   oax, oay, obx, oby;
  logic signed [OW-1:0]   ma, mb;
  logic signed [2*OW-1:0] prod, p1, p2;

  assign ma   = (ph == XP_MUL1) ? oax : oay;
  assign mb   = (ph == XP_MUL1) ? oby : obx;
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= XP_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        XP_IDLE: if (cmd.start) ph <= XP_MUL1;
        XP_MUL1: ph <= XP_MUL2;
        XP_MUL2: ph <= XP_SUM;
        XP_SUM: begin
          ph   <= XP_IDLE;
          done <= 1'b1;
        end
        default: ph <= XP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && ph == XP_IDLE) begin
      oax      <= ax;
      oay      <= ay;
      obx      <= bx;
      oby      <= by;
      add_mode <= cmd.add;
    end
    if (ph == XP_MUL1) p1 <= prod;
    if (ph == XP_MUL2) p2 <= prod;
    if (ph == XP_SUM) begin
      res <= add_mode ? ((2*OW+1)'(p1) + (2*OW+1)'(p2))
                      : ((2*OW+1)'(p1) - (2*OW+1)'(p2));
    end
  end

  assign sts.done = done;
  assign sts.neg  = res[2*OW];
  assign sts.zero = (res == '0);

endmodule

// File: rtl/incremental_angular_convex_hull.sv
// Incremental angular convex hull top: sequencer, vertex memory, multiplier, result register.
//
//   channel | role   | beat contents
//   --------+--------+------------------------------------------------------------
//   req     | sink   | req_type, point_x, point_y
//   res     | source | vertex_x, vertex_y, vertex_valid, point_added, hull_count,
//           |        | overflow, last
//   cfg     | write  | cfg_we, cfg_index, cfg_data (center_x, center_y)
//
// An add scans the vertices by angle, with a cross product for each vertex whose angle
// the signs cannot settle, then moves entries on insert or erase and runs prune tests.
// A dump reads and emits the vertices in turn; clear and other requests emit one result.
// The single shared multiplier and the memory's single read port make these steps serial.
// Synchronous reset empties the hull and zeroes the center; no clearing pass is needed.
// req.ready is high only while the sequencer is idle; a stalled result beat holds the
// sequencer in its output state until it is taken.
module incremental_angular_convex_hull #(
  parameter int HULL_CAPACITY = 64,
  parameter int COORD_BITS    = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  iach_req_if.sink                                req,
  iach_res_if.source                              res,
  input  logic                                    cfg_we,
  input  logic [iach_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic signed [COORD_BITS-1:0]            cfg_data
);
  import iach_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int RW = CW + 1;          // relative coordinates
  localparam int OW = CW + 2;          // differences of relative coordinates
  localparam int XW = 2 * OW + 1;      // product sums
  localparam int IW = $clog2(HULL_CAPACITY);
  localparam int NW = $clog2(HULL_CAPACITY + 1);

  // Sign extension of a relative coordinate to the operand width of the product unit.
  function automatic logic signed [OW-1:0] sxt(input logic signed [RW-1:0] v);
    return OW'(v);
  endfunction

  // Configuration registers.
  logic signed [CW-1:0] cen_x, cen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen_x <= '0;
      cen_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cen_x <= cfg_data;
        CFG_CENTER_Y: cen_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t              state, state_next;
  ctx_t                ctx, ctx_next;
  logic [NW-1:0]       n, n_next;           // vertex count
  logic [NW-1:0]       i, i_next;           // scan and dump index
  logic [NW-1:0]       k, k_next;           // insertion slot
  logic [NW-1:0]       pi, pi_next;         // index of the new vertex while pruning
  logic [NW-1:0]       ia, ia_next;
  logic [NW-1:0]       ib, ib_next;
  logic [NW-1:0]       j, j_next;           // shift index for insert and erase
  logic                added, added_next;
  logic                ovf, ovf_next;
  logic signed [RW-1:0] rx, rx_next, ry, ry_next;
  logic signed [RW-1:0] vax, vax_next, vay, vay_next;
  logic signed [XW-1:0] nr, nr_next;

  // Vertex memory: relative x in the upper half, relative y in the lower half.
  logic [2*RW-1:0] mem [HULL_CAPACITY];
  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic [2*RW-1:0] rd_q, wr_data;
  logic signed [RW-1:0] qx, qy;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign qx = rd_q[2*RW-1:RW];
  assign qy = rd_q[RW-1:0];

  // Shared product unit.
  xu_cmd_t              xcmd;
  xu_sts_t              xsts;
  logic signed [OW-1:0] xax, xay, xbx, xby;
  logic signed [XW-1:0] xres;

  iach_xunit #(.OW(OW)) u_xunit (
    .clk (clk),
    .rst (rst),
    .cmd (xcmd),
    .ax  (xax),
    .ay  (xay),
    .bx  (xbx),
    .by  (xby),
    .sts (xsts),
    .res (xres)
  );

  // Result register.
  logic                 o_valid;
  logic signed [CW-1:0] o_vx, o_vy;
  logic                 o_vv, o_added, o_ovf, o_last;
  logic [NW-1:0]        o_count;
  logic                 can_load, ld, ld_vv, ld_last;
  logic signed [CW-1:0] ld_vx, ld_vy;

  assign can_load = !o_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ld) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      o_vx    <= ld_vx;
      o_vy    <= ld_vy;
      o_vv    <= ld_vv;
      o_added <= added;
      o_ovf   <= ovf;
      o_count <= n;
      o_last  <= ld_last;
    end
  end

  assign res.valid        = o_valid;
  assign res.vertex_x     = o_vx;
  assign res.vertex_y     = o_vy;
  assign res.vertex_valid = o_vv;
  assign res.point_added  = o_added;
  assign res.hull_count   = o_count;
  assign res.overflow     = o_ovf;
  assign res.last         = o_last;
  assign req.ready        = (state == S_IDLE);

  // Angular class of the new point against the vertex in the read register. A point
  // at the center counts as the direction (-1, 0).
  logic signed [RW-1:0] a_x, b_x;
  logic                 a_up, b_up, a_xp, b_xp, dir_ok;
  ang_t                 dir_code, x_code, hc;
  logic                 hv;

  always_comb begin
    a_x  = (rx == '0 && ry == '0) ? '1 : rx;
    b_x  = (qx == '0 && qy == '0) ? '1 : qx;
    a_up = !ry[RW-1] && (ry != '0);
    b_up = !qy[RW-1] && (qy != '0);
    a_xp = !a_x[RW-1] && (a_x != '0);
    b_xp = !b_x[RW-1] && (b_x != '0);
    dir_ok   = 1'b1;
    dir_code = ANG_EQUAL;
    if (a_up != b_up) begin
      dir_code = a_up ? ANG_AFTER : ANG_BEFORE;
    end else if (ry == '0 && qy == '0) begin
      dir_code = (a_xp == b_xp) ? ANG_EQUAL : (a_xp ? ANG_AFTER : ANG_BEFORE);
    end else begin
      dir_ok = 1'b0;
    end
    // A positive cross product puts the new point first.
    if (xsts.zero)     x_code = ANG_EQUAL;
    else if (xsts.neg) x_code = ANG_AFTER;
    else               x_code = ANG_BEFORE;
  end

  // Cyclic neighbors for the edge test and the two prune walks.
  logic [NW-1:0] e_nx, e_pv, p_nx, p_nn, p_pv, p_pp;
  logic          x_pos;

  always_comb begin
    e_nx = (k == n) ? '0 : k;
    e_pv = (e_nx == '0) ? n - NW'(1) : e_nx - NW'(1);
    p_nx = (pi + NW'(1) == n) ? '0 : pi + NW'(1);
    p_nn = (p_nx + NW'(1) == n) ? '0 : p_nx + NW'(1);
    p_pv = (pi == '0) ? n - NW'(1) : pi - NW'(1);
    p_pp = (p_pv == '0) ? n - NW'(1) : p_pv - NW'(1);
    x_pos = !xsts.neg && !xsts.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    ctx   <= ctx_next;
    i     <= i_next;
    k     <= k_next;
    pi    <= pi_next;
    ia    <= ia_next;
    ib    <= ib_next;
    j     <= j_next;
    added <= added_next;
    ovf   <= ovf_next;
    rx    <= rx_next;
    ry    <= ry_next;
    vax   <= vax_next;
    vay   <= vay_next;
    nr    <= nr_next;
  end

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    n_next     = n;
    i_next     = i;
    k_next     = k;
    pi_next    = pi;
    ia_next    = ia;
    ib_next    = ib;
    j_next     = j;
    added_next = added;
    ovf_next   = ovf;
    rx_next    = rx;
    ry_next    = ry;
    vax_next   = vax;
    vay_next   = vay;
    nr_next    = nr;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = {rx, ry};
    xcmd       = '0;
    xax        = '0;
    xay        = '0;
    xbx        = '0;
    xby        = '0;
    ld         = 1'b0;
    ld_vx      = '0;
    ld_vy      = '0;
    ld_vv      = 1'b0;
    ld_last    = 1'b1;
    hv         = 1'b0;
    hc         = ANG_EQUAL;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          added_next = 1'b0;
          ovf_next   = 1'b0;
          i_next     = '0;
          case (req.req_type)
            REQ_ADD: begin
              rx_next    = RW'(req.point_x) - RW'(cen_x);
              ry_next    = RW'(req.point_y) - RW'(cen_y);
              k_next     = n;
              state_next = S_SCAN_RD;
            end
            REQ_DUMP: state_next = (n == '0) ? S_EMIT : S_DUMP_RD;
            REQ_CLEAR: begin
              n_next     = '0;
              state_next = S_EMIT;
            end
            default: state_next = S_EMIT;
          endcase
        end
      end

      S_EMIT: begin
        if (can_load) begin
          ld         = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = i[IW-1:0];
        state_next = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (can_load) begin
          ld      = 1'b1;
          ld_vx   = CW'(qx + RW'(cen_x));
          ld_vy   = CW'(qy + RW'(cen_y));
          ld_vv   = 1'b1;
          ld_last = (i + NW'(1) == n);
          i_next  = i + NW'(1);
          state_next = (i + NW'(1) == n) ? S_IDLE : S_DUMP_RD;
        end
      end

      // Angular scan: find an equal-angle vertex or the first vertex after the point.
      S_SCAN_RD: begin
        if (i == n) begin
          state_next = S_SCAN_END;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = i[IW-1:0];
          state_next = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (dir_ok) begin
          hv = 1'b1;
          hc = dir_code;
        end else begin
          xcmd.start = 1'b1;
          xax        = sxt(a_x);
          xay        = sxt(ry);
          xbx        = sxt(b_x);
          xby        = sxt(qy);
          state_next = S_SCAN_W;
        end
      end

      S_SCAN_W: begin
        if (xsts.done) begin
          hv = 1'b1;
          hc = x_code;
        end
      end

      S_SCAN_END: begin
        if (n < NW'(2)) begin
          j_next     = n;
          state_next = S_INS_RD;
        end else begin
          ia_next    = e_pv;
          ib_next    = e_nx;
          ctx_next   = CX_EDGE;
          state_next = S_PAIR_A;
        end
      end

      // Equal angle: compare squared distances; the stored vertex stays in rd_q.
      S_EQ_N1: begin
        xcmd.start = 1'b1;
        xcmd.add   = 1'b1;
        xax        = sxt(rx);
        xby        = sxt(rx);
        xay        = sxt(ry);
        xbx        = sxt(ry);
        state_next = S_EQ_N1W;
      end

      S_EQ_N1W: begin
        if (xsts.done) begin
          nr_next    = xres;
          xcmd.start = 1'b1;
          xcmd.add   = 1'b1;
          xax        = sxt(qx);
          xby        = sxt(qx);
          xay        = sxt(qy);
          xbx        = sxt(qy);
          state_next = S_EQ_N2W;
        end
      end

      S_EQ_N2W: begin
        if (xsts.done) begin
          if (nr > xres) begin
            wr_en      = 1'b1;
            wr_addr    = pi[IW-1:0];
            added_next = 1'b1;
            ctx_next   = CX_PRA;
            state_next = S_PR_CHK;
          end else begin
            state_next = S_EMIT;
          end
        end
      end

      // Pair test: read vertices ia and ib, then one cross product.
      S_PAIR_A: begin
        rd_en      = 1'b1;
        rd_addr    = ia[IW-1:0];
        state_next = S_PAIR_B;
      end

      S_PAIR_B: begin
        vax_next   = qx;
        vay_next   = qy;
        rd_en      = 1'b1;
        rd_addr    = ib[IW-1:0];
        state_next = S_PAIR_X;
      end

      S_PAIR_X: begin
        xcmd.start = 1'b1;
        if (ctx == CX_EDGE) begin
          xax = sxt(rx) - sxt(vax);
          xay = sxt(ry) - sxt(vay);
          xbx = sxt(qx) - sxt(vax);
          xby = sxt(qy) - sxt(vay);
        end else begin
          xax = sxt(vax) - sxt(rx);
          xay = sxt(vay) - sxt(ry);
          xbx = sxt(qx) - sxt(rx);
          xby = sxt(qy) - sxt(ry);
        end
        state_next = S_PAIR_W;
      end

      S_PAIR_W: begin
        if (xsts.done) begin
          case (ctx)
            CX_EDGE: begin
              if (!x_pos) begin
                state_next = S_EMIT;
              end else if (n >= NW'(HULL_CAPACITY)) begin
                ovf_next   = 1'b1;
                state_next = S_EMIT;
              end else begin
                j_next     = n;
                state_next = S_INS_RD;
              end
            end
            CX_PRA: begin
              if (x_pos) begin
                j_next = ib;
                if (ib < pi) pi_next = pi - NW'(1);
                state_next = S_ER_RD;
              end else begin
                ctx_next   = CX_PRB;
                state_next = S_PR_CHK;
              end
            end
            default: begin
              if (xsts.neg) begin
                j_next = ib;
                if (ib < pi) pi_next = pi - NW'(1);
                state_next = S_ER_RD;
              end else begin
                state_next = S_EMIT;
              end
            end
          endcase
        end
      end

      // Insert at k: move entries up from the top, then write the new point.
      S_INS_RD: begin
        if (j > k) begin
          rd_en      = 1'b1;
          rd_addr    = IW'(j - NW'(1));
          state_next = S_INS_WR;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = k[IW-1:0];
          n_next     = n + NW'(1);
          added_next = 1'b1;
          pi_next    = k;
          ctx_next   = CX_PRA;
          state_next = S_PR_CHK;
        end
      end

      S_INS_WR: begin
        wr_en      = 1'b1;
        wr_addr    = j[IW-1:0];
        wr_data    = rd_q;
        j_next     = j - NW'(1);
        state_next = S_INS_RD;
      end

      // Prune walks run only while more than two vertices remain.
      S_PR_CHK: begin
        if (n > NW'(2)) begin
          if (ctx == CX_PRA) begin
            ia_next = p_nn;
            ib_next = p_nx;
          end else begin
            ia_next = p_pp;
            ib_next = p_pv;
          end
          state_next = S_PAIR_A;
        end else begin
          state_next = S_EMIT;
        end
      end

      // Erase at j: move entries down by one.
      S_ER_RD: begin
        if (j + NW'(1) < n) begin
          rd_en      = 1'b1;
          rd_addr    = IW'(j + NW'(1));
          state_next = S_ER_WR;
        end else begin
          n_next     = n - NW'(1);
          state_next = S_PR_CHK;
        end
      end

      S_ER_WR: begin
        wr_en      = 1'b1;
        wr_addr    = j[IW-1:0];
        wr_data    = rd_q;
        j_next     = j + NW'(1);
        state_next = S_ER_RD;
      end

      default: state_next = S_IDLE;
    endcase

    if (hv) begin
      if (hc == ANG_EQUAL) begin
        pi_next    = i;
        state_next = S_EQ_N1;
      end else begin
        if (hc == ANG_BEFORE && k == n) k_next = i;
        i_next     = i + NW'(1);
        state_next = S_SCAN_RD;
      end
    end
  end

`ifndef SYNTH
  // The vertex count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(HULL_CAPACITY))
    else $error("vertex count above capacity");

  // The count moves by one vertex at a time, except for a clear.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (n != $past(n)) |->
      (n == $past(n) + NW'(1) || n == $past(n) - NW'(1) || n == '0))
    else $error("vertex count jumped");

  // An overflow result is only reported on a full hull.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.overflow) |-> (res.hull_count == NW'(HULL_CAPACITY)))
    else $error("overflow reported on a hull with room");

  // A dumped vertex never carries add status.
  a_dump_flags: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.vertex_valid) |-> (!res.point_added && !res.overflow))
    else $error("dump beat carries add status");
`endif

endmodule
